FILE: rtl/hsv2rgb_pkg.sv
`default_nettype none

package hsv2rgb_pkg;

    localparam int SECTOR_BITS  = 3;
    localparam int SECTOR_COUNT = 6;

    // hue sector, red at zero degrees, counting up by sixty degrees
    typedef enum logic [SECTOR_BITS-1:0] {
        SEC_RED_TO_YELLOW   = 3'd0,
        SEC_YELLOW_TO_GREEN = 3'd1,
        SEC_GREEN_TO_CYAN   = 3'd2,
        SEC_CYAN_TO_BLUE    = 3'd3,
        SEC_BLUE_TO_MAGENTA = 3'd4,
        SEC_MAGENTA_TO_RED  = 3'd5
    } t_sector;

    // load enables for the two register stages inside one sub-block
    typedef struct packed {
        logic load_a;
        logic load_b;
    } t_pipe_ctrl;

    // sector codes past the last one wrap around the colour circle
    function automatic t_sector wrap_sector(input logic [SECTOR_BITS-1:0] raw);
        logic [SECTOR_BITS-1:0] wrapped;
        if (raw >= SECTOR_BITS'(SECTOR_COUNT)) begin
            wrapped = raw - SECTOR_BITS'(SECTOR_COUNT);
        end else begin
            wrapped = raw;
        end
        return t_sector'(wrapped);
    endfunction

endpackage

`default_nettype wire

FILE: rtl/hsv2rgb_chroma.sv
`default_nettype none

module hsv2rgb_chroma
    import hsv2rgb_pkg::*;
#(
    parameter int CHANNEL_BITS      = 8,
    parameter int HUE_FRACTION_BITS = 8
) (
    input  wire logic                                       i_clk,
    input  wire t_pipe_ctrl                                 i_ctrl,
    input  wire logic [HUE_FRACTION_BITS+SECTOR_BITS-1:0]   i_hue,
    input  wire logic [CHANNEL_BITS-1:0]                    i_saturation,
    input  wire logic [CHANNEL_BITS-1:0]                    i_brightness,
    output t_sector                                         o_sector,
    output logic [HUE_FRACTION_BITS-1:0]                    o_frac,
    output logic [CHANNEL_BITS-1:0]                         o_brightness,
    output logic [CHANNEL_BITS-1:0]                         o_chroma
);

    localparam int CB = CHANNEL_BITS;
    localparam int FB = HUE_FRACTION_BITS;
    localparam int PW = 2 * CB;

    // stage 1: value times saturation
    t_sector        r_sector1;
    logic [FB-1:0]  r_frac1;
    logic [CB-1:0]  r_val1;
    logic [PW-1:0]  r_prod1;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load_a) begin
            r_sector1 <= wrap_sector(i_hue[FB+SECTOR_BITS-1:FB]);
            r_frac1   <= i_hue[FB-1:0];
            r_val1    <= i_brightness;
            r_prod1   <= {{CB{1'b0}}, i_brightness} * {{CB{1'b0}}, i_saturation};
        end
    end

    // stage 2: divide by the full-scale code 2^CB-1
    // exact for any product of two channel codes: (x + (x >> CB) + 1) >> CB
    logic [PW:0]    n_sum;
    logic [CB-1:0]  n_chroma;

    assign n_sum    = {1'b0, r_prod1} + {{(CB+1){1'b0}}, r_prod1[PW-1:CB]} + (PW+1)'(1);
    assign n_chroma = n_sum[PW-1:CB];

    t_sector        r_sector2;
    logic [FB-1:0]  r_frac2;
    logic [CB-1:0]  r_val2;
    logic [CB-1:0]  r_chroma2;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load_b) begin
            r_sector2 <= r_sector1;
            r_frac2   <= r_frac1;
            r_val2    <= r_val1;
            r_chroma2 <= n_chroma;
        end
    end

    assign o_sector     = r_sector2;
    assign o_frac       = r_frac2;
    assign o_brightness = r_val2;
    assign o_chroma     = r_chroma2;

endmodule

`default_nettype wire

FILE: rtl/hsv2rgb_mix.sv
`default_nettype none

module hsv2rgb_mix
    import hsv2rgb_pkg::*;
#(
    parameter int CHANNEL_BITS      = 8,
    parameter int HUE_FRACTION_BITS = 8
) (
    input  wire logic                           i_clk,
    input  wire t_pipe_ctrl                     i_ctrl,
    input  wire t_sector                        i_sector,
    input  wire logic [HUE_FRACTION_BITS-1:0]   i_frac,
    input  wire logic [CHANNEL_BITS-1:0]        i_brightness,
    input  wire logic [CHANNEL_BITS-1:0]        i_chroma,
    output logic [CHANNEL_BITS-1:0]             o_red,
    output logic [CHANNEL_BITS-1:0]             o_green,
    output logic [CHANNEL_BITS-1:0]             o_blue
);

    localparam int CB = CHANNEL_BITS;
    localparam int FB = HUE_FRACTION_BITS;
    localparam int RW = CB + FB + 1;

    // stage 3: ramp product, rising in even sectors and falling in odd ones
    logic [FB:0] n_weight;

    always_comb begin
        if (i_sector[0]) begin
            n_weight = {1'b1, {FB{1'b0}}} - {1'b0, i_frac};
        end else begin
            n_weight = {1'b0, i_frac};
        end
    end

    t_sector        r_sector3;
    logic [CB-1:0]  r_chroma3;
    logic [CB-1:0]  r_grey3;
    logic [RW-1:0]  r_ramp_prod3;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load_a) begin
            r_sector3    <= i_sector;
            r_chroma3    <= i_chroma;
            r_grey3      <= i_brightness - i_chroma;
            r_ramp_prod3 <= {{(FB+1){1'b0}}, i_chroma} * {{CB{1'b0}}, n_weight};
        end
    end

    // stage 4: route chroma and ramp per sector, then lift by the grey level
    logic [CB-1:0] n_ramp;
    logic [CB-1:0] n_r;
    logic [CB-1:0] n_g;
    logic [CB-1:0] n_b;

    assign n_ramp = r_ramp_prod3[CB+FB-1:FB];

    always_comb begin
        unique case (r_sector3)
            SEC_RED_TO_YELLOW: begin
                n_r = r_chroma3; n_g = n_ramp;    n_b = '0;
            end
            SEC_YELLOW_TO_GREEN: begin
                n_r = n_ramp;    n_g = r_chroma3; n_b = '0;
            end
            SEC_GREEN_TO_CYAN: begin
                n_r = '0;        n_g = r_chroma3; n_b = n_ramp;
            end
            SEC_CYAN_TO_BLUE: begin
                n_r = '0;        n_g = n_ramp;    n_b = r_chroma3;
            end
            SEC_BLUE_TO_MAGENTA: begin
                n_r = n_ramp;    n_g = '0;        n_b = r_chroma3;
            end
            default: begin
                n_r = r_chroma3; n_g = '0;        n_b = n_ramp;
            end
        endcase
    end

    logic [CB-1:0] r_red;
    logic [CB-1:0] r_green;
    logic [CB-1:0] r_blue;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load_b) begin
            r_red   <= n_r + r_grey3;
            r_green <= n_g + r_grey3;
            r_blue  <= n_b + r_grey3;
        end
    end

    assign o_red   = r_red;
    assign o_green = r_green;
    assign o_blue  = r_blue;

endmodule

`default_nettype wire

FILE: rtl/hsv_to_rgb_pixel.sv
`default_nettype none

// HSV to RGB pixel converter. One pixel enters per clock and its RGB colour
// leaves from the last stage; a stall on the output holds the pipeline, and a
// stage left empty by an input gap is filled even while the output waits.
// The four stages are value times saturation, the divide by full scale, the
// ramp product, and the channel routing with the grey lift, which hold the
// two multipliers each behind a register of their own. Hue holds the sector
// above HUE_FRACTION_BITS and the fraction below it; sector codes 6 and 7
// wrap to 0 and 1. Saturation and brightness are full scale at all ones.
module hsv_to_rgb_pixel
    import hsv2rgb_pkg::*;
#(
    parameter int CHANNEL_BITS      = 8,
    parameter int HUE_FRACTION_BITS = 8
) (
    input  wire logic                                       i_clk,
    input  wire logic                                       i_rst_n,
    input  wire logic                                       i_in_valid,
    output logic                                            o_in_ready,
    input  wire logic [HUE_FRACTION_BITS+SECTOR_BITS-1:0]   i_hue,
    input  wire logic [CHANNEL_BITS-1:0]                    i_saturation,
    input  wire logic [CHANNEL_BITS-1:0]                    i_brightness,
    output logic                                            o_out_valid,
    input  wire logic                                       i_out_ready,
    output logic [CHANNEL_BITS-1:0]                         o_red,
    output logic [CHANNEL_BITS-1:0]                         o_green,
    output logic [CHANNEL_BITS-1:0]                         o_blue
);

    localparam int STAGES = 4;

    logic [STAGES-1:0] r_vld;
    logic [STAGES-1:0] stage_en;
    logic [STAGES-1:0] n_vld;

    // a stage loads when it is empty or its content moves on
    always_comb begin
        stage_en[STAGES-1] = !r_vld[STAGES-1] || i_out_ready;
        for (int k = STAGES - 2; k >= 0; k--) begin
            stage_en[k] = !r_vld[k] || stage_en[k+1];
        end
        n_vld = r_vld;
        if (stage_en[0]) begin
            n_vld[0] = i_in_valid;
        end
        for (int k = 1; k < STAGES; k++) begin
            if (stage_en[k]) begin
                n_vld[k] = r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    t_pipe_ctrl front_ctrl;
    t_pipe_ctrl back_ctrl;

    assign front_ctrl = '{load_a: stage_en[0], load_b: stage_en[1]};
    assign back_ctrl  = '{load_a: stage_en[2], load_b: stage_en[3]};

    t_sector                        mid_sector;
    logic [HUE_FRACTION_BITS-1:0]   mid_frac;
    logic [CHANNEL_BITS-1:0]        mid_brightness;
    logic [CHANNEL_BITS-1:0]        mid_chroma;

    hsv2rgb_chroma #(
        .CHANNEL_BITS      (CHANNEL_BITS),
        .HUE_FRACTION_BITS (HUE_FRACTION_BITS)
    ) u_chroma (
        .i_clk        (i_clk),
        .i_ctrl       (front_ctrl),
        .i_hue        (i_hue),
        .i_saturation (i_saturation),
        .i_brightness (i_brightness),
        .o_sector     (mid_sector),
        .o_frac       (mid_frac),
        .o_brightness (mid_brightness),
        .o_chroma     (mid_chroma)
    );

    hsv2rgb_mix #(
        .CHANNEL_BITS      (CHANNEL_BITS),
        .HUE_FRACTION_BITS (HUE_FRACTION_BITS)
    ) u_mix (
        .i_clk        (i_clk),
        .i_ctrl       (back_ctrl),
        .i_sector     (mid_sector),
        .i_frac       (mid_frac),
        .i_brightness (mid_brightness),
        .i_chroma     (mid_chroma),
        .o_red        (o_red),
        .o_green      (o_green),
        .o_blue       (o_blue)
    );

    assign o_in_ready  = stage_en[0];
    assign o_out_valid = r_vld[STAGES-1];

endmodule

`default_nettype wire

FILE: rtl/hsv2rgb_checker.sv
`default_nettype none

module hsv2rgb_checker
    import hsv2rgb_pkg::*;
#(
    parameter int CHANNEL_BITS      = 8,
    parameter int HUE_FRACTION_BITS = 8
) (
    input  wire logic                                       i_clk,
    input  wire logic                                       i_rst_n,
    input  wire logic                                       i_in_valid,
    input  wire logic                                       o_in_ready,
    input  wire logic [HUE_FRACTION_BITS+SECTOR_BITS-1:0]   i_hue,
    input  wire logic [CHANNEL_BITS-1:0]                    i_saturation,
    input  wire logic [CHANNEL_BITS-1:0]                    i_brightness,
    input  wire logic                                       o_out_valid,
    input  wire logic                                       i_out_ready,
    input  wire logic [CHANNEL_BITS-1:0]                    o_red,
    input  wire logic [CHANNEL_BITS-1:0]                    o_green,
    input  wire logic [CHANNEL_BITS-1:0]                    o_blue
);

    // a waiting input transfer stays offered with the same pixel
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_ready |=>
            i_in_valid && $stable(i_hue) && $stable(i_saturation)
            && $stable(i_brightness))
        else $error("input transfer dropped or changed while stalled");

    // a waiting result stays offered with the same colour
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_red) && $stable(o_green) && $stable(o_blue))
        else $error("output transfer dropped or changed while stalled");

    // pipeline comes out of reset empty
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

    // a free output side never holds back the input
    a_ready_flow: assert property (@(posedge i_clk)
        i_out_ready |-> o_in_ready)
        else $error("input stalled while output side is ready");

    // an empty output stage leaves room for a new transfer
    a_ready_empty: assert property (@(posedge i_clk)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with output stage empty");

endmodule

bind hsv_to_rgb_pixel hsv2rgb_checker #(
    .CHANNEL_BITS      (CHANNEL_BITS),
    .HUE_FRACTION_BITS (HUE_FRACTION_BITS)
) u_hsv2rgb_checker (.*);

`default_nettype wire
